// ===== hdl/rbs_pkg.sv =====
// Shared types, constants and codes for the rigid body step block.
`timescale 1ns / 1ps
package rbs_pkg;

  localparam int MAX_BODIES = 64;
  localparam int IDX_W      = $clog2(MAX_BODIES);
  localparam int CNT_W      = $clog2(MAX_BODIES + 1);

  // Configuration register indexes
  localparam logic [1:0] REG_TIME_STEP = 2'd0;
  localparam logic [1:0] REG_GRAVITY_X = 2'd1;
  localparam logic [1:0] REG_GRAVITY_Y = 2'd2;
  localparam logic [1:0] REG_GRAVITY_Z = 2'd3;

  localparam logic [15:0] TIME_STEP_RESET = 16'd1092;
  localparam logic [31:0] GRAVITY_Y_RESET = 32'hFFF6_30A4;

  // Body flag bit positions
  localparam int FLAG_RIGID     = 0;
  localparam int FLAG_KINEMATIC = 1;
  localparam int FLAG_GRAVITY   = 2;
  localparam int FLAG_COLLIDER  = 3;
  localparam int FLAG_TRIGGER   = 4;

  // Integration micro-operations, one multiply each
  localparam logic [1:0] OP_FACTOR = 2'd0;
  localparam logic [1:0] OP_GRAV   = 2'd1;
  localparam logic [1:0] OP_DRAG   = 2'd2;
  localparam logic [1:0] OP_POS    = 2'd3;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [2:0][30:0] ext;
    logic [15:0]      drag;
    logic [4:0]       flags;
  } body_t;

  localparam int BODY_W = $bits(body_t);

  typedef struct packed {
    logic [IDX_W-1:0] addr;
    logic             we;
    logic             wr_load;
    logic             cap_a;
    logic             op_en;
    logic [1:0]       op_kind;
    logic [1:0]       op_axis;
    logic             col_test;
    logic             cap_out;
    logic             out_final;
  } cmd_t;

  typedef struct packed {
    logic int_ok;
    logic col_ok;
  } stat_t;

endpackage

// ===== hdl/rigid_body_step_aabb_resolve.sv =====
// Top level of the rigid body frame step with box collision resolve.
//
// Bodies arrive one per transfer on the input channel (in_valid/in_ready)
// and are stored in slot order, up to 64; further bodies are dropped. A
// transfer with last_body set ends loading and runs one frame: integration
// skips the bodies that are not dynamic and steps each dynamic body, one
// multiply per cycle through a shared multiplier; the collision pass tests
// each dynamic collider against every other stored body, one read at a
// time through the single read port of the body store. Then every stored
// body is sent on the output channel (out_valid/out_ready); final_result
// marks the last one. A result waits in the output registers while
// out_ready is low, and the block holds. No input is taken during a frame.
// Configuration writes on cfg_we/cfg_index/cfg_data land at once and
// belong between frames. Synchronous reset empties the body list, loads
// the register defaults and returns to loading; no clearing pass is needed.
`timescale 1ns / 1ps
module rigid_body_step_aabb_resolve (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  input  logic signed [31:0] vel_z,
  input  logic [30:0]        extent_x,
  input  logic [30:0]        extent_y,
  input  logic [30:0]        extent_z,
  input  logic [15:0]        drag_coef,
  input  logic [4:0]         body_flags,
  input  logic               last_body,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] new_pos_x,
  output logic signed [31:0] new_pos_y,
  output logic signed [31:0] new_pos_z,
  output logic signed [31:0] new_vel_x,
  output logic signed [31:0] new_vel_y,
  output logic signed [31:0] new_vel_z,
  output logic               final_result
);

  rbs_pkg::cmd_t  cmd;
  rbs_pkg::stat_t stat;

  rbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .last_body(last_body),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rbs_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .vel_x       (vel_x),
    .vel_y       (vel_y),
    .vel_z       (vel_z),
    .extent_x    (extent_x),
    .extent_y    (extent_y),
    .extent_z    (extent_z),
    .drag_coef   (drag_coef),
    .body_flags  (body_flags),
    .cmd         (cmd),
    .stat        (stat),
    .new_pos_x   (new_pos_x),
    .new_pos_y   (new_pos_y),
    .new_pos_z   (new_pos_z),
    .new_vel_x   (new_vel_x),
    .new_vel_y   (new_vel_y),
    .new_vel_z   (new_vel_z),
    .final_result(final_result)
  );

endmodule

// ===== hdl/rbs_ram.sv =====
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
module rbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/rbs_datapath.sv =====
// Datapath: body store, config registers, shared multiplier, overlap test, output regs.
`timescale 1ns / 1ps
module rbs_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic signed [31:0]  pos_z,
  input  logic signed [31:0]  vel_x,
  input  logic signed [31:0]  vel_y,
  input  logic signed [31:0]  vel_z,
  input  logic [30:0]         extent_x,
  input  logic [30:0]         extent_y,
  input  logic [30:0]         extent_z,
  input  logic [15:0]         drag_coef,
  input  logic [4:0]          body_flags,
  input  rbs_pkg::cmd_t       cmd,
  output rbs_pkg::stat_t      stat,
  output logic signed [31:0]  new_pos_x,
  output logic signed [31:0]  new_pos_y,
  output logic signed [31:0]  new_pos_z,
  output logic signed [31:0]  new_vel_x,
  output logic signed [31:0]  new_vel_y,
  output logic signed [31:0]  new_vel_z,
  output logic                final_result
);

  logic [15:0]         time_step;
  logic [2:0][31:0]    gravity;
  rbs_pkg::body_t      in_body;
  rbs_pkg::body_t      rd_body;
  rbs_pkg::body_t      a_body;
  rbs_pkg::body_t      wr_body;
  logic [rbs_pkg::BODY_W-1:0] rd_word;
  logic signed [33:0]  factor;
  logic signed [33:0]  mul_a;
  logic signed [33:0]  mul_b;
  logic signed [67:0]  prod;
  logic [2:0]          touch;
  logic [2:0][33:0]    twod;
  logic [2:0][31:0]    ext_sum;
  logic signed [34:0]  ov2;
  logic signed [34:0]  ov2_round;
  logic                push;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step  <= rbs_pkg::TIME_STEP_RESET;
      gravity[0] <= '0;
      gravity[1] <= rbs_pkg::GRAVITY_Y_RESET;
      gravity[2] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rbs_pkg::REG_TIME_STEP: time_step  <= cfg_data[15:0];
        rbs_pkg::REG_GRAVITY_X: gravity[0] <= cfg_data;
        rbs_pkg::REG_GRAVITY_Y: gravity[1] <= cfg_data;
        rbs_pkg::REG_GRAVITY_Z: gravity[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pack the incoming body
  always_comb begin
    in_body.pos   = {pos_z, pos_y, pos_x};
    in_body.vel   = {vel_z, vel_y, vel_x};
    in_body.ext   = {extent_z, extent_y, extent_x};
    in_body.drag  = drag_coef;
    in_body.flags = body_flags;
  end

  assign wr_body = cmd.wr_load ? in_body : a_body;

  rbs_ram #(
    .WIDTH(rbs_pkg::BODY_W),
    .DEPTH(rbs_pkg::MAX_BODIES)
  ) u_store (
    .clk    (clk),
    .we     (cmd.we),
    .wr_addr(cmd.addr),
    .wr_data(wr_body),
    .rd_addr(cmd.addr),
    .rd_data(rd_word)
  );

  assign rd_body = rbs_pkg::body_t'(rd_word);

  // Flag status of the body just read
  assign stat.int_ok = rd_body.flags[rbs_pkg::FLAG_RIGID] &&
                       !rd_body.flags[rbs_pkg::FLAG_KINEMATIC];
  assign stat.col_ok = rd_body.flags[rbs_pkg::FLAG_RIGID] &&
                       rd_body.flags[rbs_pkg::FLAG_COLLIDER] &&
                       !rd_body.flags[rbs_pkg::FLAG_KINEMATIC] &&
                       !rd_body.flags[rbs_pkg::FLAG_TRIGGER];

  // Select multiplier operands for the current micro-operation
  always_comb begin
    mul_a = '0;
    mul_b = $signed({18'b0, time_step});
    case (cmd.op_kind)
      rbs_pkg::OP_FACTOR: mul_a = $signed({18'b0, a_body.drag});
      rbs_pkg::OP_GRAV: begin
        mul_a = $signed({{2{gravity[cmd.op_axis][31]}}, gravity[cmd.op_axis]});
      end
      rbs_pkg::OP_DRAG: begin
        mul_a = $signed({{2{a_body.vel[cmd.op_axis][31]}}, a_body.vel[cmd.op_axis]});
        mul_b = factor;
      end
      rbs_pkg::OP_POS: begin
        mul_a = $signed({{2{a_body.vel[cmd.op_axis][31]}}, a_body.vel[cmd.op_axis]});
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  // Overlap test of body A against the body just read
  always_comb begin
    logic signed [32:0] d;
    logic [32:0]        ad;
    for (int a = 0; a < 3; a++) begin
      d = $signed({a_body.pos[a][31], a_body.pos[a]}) -
          $signed({rd_body.pos[a][31], rd_body.pos[a]});
      ad = d[32] ? 33'(-d) : 33'(d);
      twod[a] = {ad, 1'b0};
      ext_sum[a] = {1'b0, a_body.ext[a]} + {1'b0, rd_body.ext[a]};
      touch[a] = {2'b0, ext_sum[a]} >= twod[a];
    end
    ov2 = $signed({3'b0, ext_sum[1]}) - $signed({1'b0, twod[1]});
    ov2_round = ov2 + 35'sd1;
    push = rd_body.flags[rbs_pkg::FLAG_COLLIDER] &&
           !rd_body.flags[rbs_pkg::FLAG_TRIGGER] && (&touch) &&
           !ov2[34] && (ov2 != 35'sd0) && a_body.vel[1][31] &&
           ($signed(a_body.pos[1]) > $signed(rd_body.pos[1]));
  end

  // Update body A: capture, integrate, push out of boxes below
  always_ff @(posedge clk) begin
    if (cmd.cap_a) begin
      a_body <= rd_body;
    end else if (cmd.op_en) begin
      case (cmd.op_kind)
        rbs_pkg::OP_FACTOR: factor <= 34'sd16777216 - $signed(prod[33:0]);
        rbs_pkg::OP_GRAV: begin
          if (a_body.flags[rbs_pkg::FLAG_GRAVITY]) begin
            a_body.vel[cmd.op_axis] <= a_body.vel[cmd.op_axis] + prod[47:16];
          end
        end
        rbs_pkg::OP_DRAG: a_body.vel[cmd.op_axis] <= prod[55:24];
        rbs_pkg::OP_POS:  a_body.pos[cmd.op_axis] <= a_body.pos[cmd.op_axis] + prod[47:16];
        default: ;
      endcase
    end else if (cmd.col_test && push) begin
      a_body.pos[1] <= a_body.pos[1] + ov2_round[32:1];
      a_body.vel[1] <= '0;
    end
  end

  // Load output registers
  always_ff @(posedge clk) begin
    if (cmd.cap_out) begin
      new_pos_x    <= rd_body.pos[0];
      new_pos_y    <= rd_body.pos[1];
      new_pos_z    <= rd_body.pos[2];
      new_vel_x    <= rd_body.vel[0];
      new_vel_y    <= rd_body.vel[1];
      new_vel_z    <= rd_body.vel[2];
      final_result <= cmd.out_final;
    end
  end

endmodule

// ===== hdl/rbs_ctrl.sv =====
// Controller: load, integrate, resolve and emit sequencing.
`timescale 1ns / 1ps
module rbs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           last_body,
  output logic           out_valid,
  input  logic           out_ready,
  input  rbs_pkg::stat_t stat,
  output rbs_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_IRD   = 4'd1;
  localparam logic [3:0] S_ICAP  = 4'd2;
  localparam logic [3:0] S_IOP   = 4'd3;
  localparam logic [3:0] S_IWR   = 4'd4;
  localparam logic [3:0] S_CRDA  = 4'd5;
  localparam logic [3:0] S_CCAPA = 4'd6;
  localparam logic [3:0] S_CRDB  = 4'd7;
  localparam logic [3:0] S_CTEST = 4'd8;
  localparam logic [3:0] S_CWR   = 4'd9;
  localparam logic [3:0] S_ERD   = 4'd10;
  localparam logic [3:0] S_ECAP  = 4'd11;
  localparam logic [3:0] S_EOUT  = 4'd12;

  localparam int CW = rbs_pkg::CNT_W;
  localparam int IW = rbs_pkg::IDX_W;

  logic [3:0]    state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] i, i_next;
  logic [CW-1:0] j, j_next;
  logic [1:0]    op_kind, op_kind_next;
  logic [1:0]    op_axis, op_axis_next;
  logic          accept;
  logic          store;
  logic          i_last;
  logic          j_last;

  assign in_ready  = (state == S_LOAD);
  assign out_valid = (state == S_EOUT);
  assign accept    = in_valid && in_ready;
  assign store     = accept && (count < CW'(rbs_pkg::MAX_BODIES));
  assign i_last    = (i + CW'(1)) == count;
  assign j_last    = (j + CW'(1)) == count;

  // Advance the sequence
  always_comb begin
    state_next   = state;
    count_next   = count;
    i_next       = i;
    j_next       = j;
    op_kind_next = op_kind;
    op_axis_next = op_axis;
    unique case (state)
      S_LOAD: begin
        if (store) begin
          count_next = count + CW'(1);
        end
        if (accept && last_body) begin
          i_next     = '0;
          state_next = S_IRD;
        end
      end
      S_IRD: state_next = S_ICAP;
      S_ICAP: begin
        if (stat.int_ok) begin
          op_kind_next = rbs_pkg::OP_FACTOR;
          op_axis_next = '0;
          state_next   = S_IOP;
        end else if (i_last) begin
          i_next     = '0;
          state_next = S_CRDA;
        end else begin
          i_next     = i + CW'(1);
          state_next = S_IRD;
        end
      end
      S_IOP: begin
        case (op_kind)
          rbs_pkg::OP_FACTOR: op_kind_next = rbs_pkg::OP_GRAV;
          rbs_pkg::OP_GRAV:   op_kind_next = rbs_pkg::OP_DRAG;
          rbs_pkg::OP_DRAG:   op_kind_next = rbs_pkg::OP_POS;
          default: begin
            if (op_axis == 2'd2) begin
              state_next = S_IWR;
            end else begin
              op_axis_next = op_axis + 2'd1;
              op_kind_next = rbs_pkg::OP_GRAV;
            end
          end
        endcase
      end
      S_IWR: begin
        if (i_last) begin
          i_next     = '0;
          state_next = S_CRDA;
        end else begin
          i_next     = i + CW'(1);
          state_next = S_IRD;
        end
      end
      S_CRDA: state_next = S_CCAPA;
      S_CCAPA: begin
        if (stat.col_ok) begin
          j_next     = '0;
          state_next = S_CRDB;
        end else if (i_last) begin
          i_next     = '0;
          state_next = S_ERD;
        end else begin
          i_next     = i + CW'(1);
          state_next = S_CRDA;
        end
      end
      S_CRDB: begin
        if (j != i) begin
          state_next = S_CTEST;
        end else if (j_last) begin
          state_next = S_CWR;
        end else begin
          j_next = j + CW'(1);
        end
      end
      S_CTEST: begin
        if (j_last) begin
          state_next = S_CWR;
        end else begin
          j_next     = j + CW'(1);
          state_next = S_CRDB;
        end
      end
      S_CWR: begin
        if (i_last) begin
          i_next     = '0;
          state_next = S_ERD;
        end else begin
          i_next     = i + CW'(1);
          state_next = S_CRDA;
        end
      end
      S_ERD:  state_next = S_ECAP;
      S_ECAP: state_next = S_EOUT;
      S_EOUT: begin
        if (out_ready) begin
          if (i_last) begin
            count_next = '0;
            state_next = S_LOAD;
          end else begin
            i_next     = i + CW'(1);
            state_next = S_ERD;
          end
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  // Hold control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_LOAD;
      count   <= '0;
      i       <= '0;
      j       <= '0;
      op_kind <= rbs_pkg::OP_FACTOR;
      op_axis <= '0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      i       <= i_next;
      j       <= j_next;
      op_kind <= op_kind_next;
      op_axis <= op_axis_next;
    end
  end

  // Drive datapath commands
  always_comb begin
    unique case (state)
      S_LOAD:  cmd.addr = count[IW-1:0];
      S_CRDB:  cmd.addr = j[IW-1:0];
      default: cmd.addr = i[IW-1:0];
    endcase
    cmd.we        = store || (state == S_IWR) || (state == S_CWR);
    cmd.wr_load   = (state == S_LOAD);
    cmd.cap_a     = (state == S_ICAP) || (state == S_CCAPA);
    cmd.op_en     = (state == S_IOP);
    cmd.op_kind   = op_kind;
    cmd.op_axis   = op_axis;
    cmd.col_test  = (state == S_CTEST);
    cmd.cap_out   = (state == S_ECAP);
    cmd.out_final = i_last;
  end

endmodule

// ===== hdl/rbs_checker.sv =====
// Port-level checker for the rigid body step block, with its bind.
`timescale 1ns / 1ps
module rbs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        last_body,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] new_pos_y,
  input logic        final_result
);

  // Reset returns to loading with no result pending
  a_reset: assert property (@(posedge clk) rst |=> in_ready && !out_valid)
    else $error("not loading after reset");

  // Loading and emitting never overlap
  a_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input ready while a result is offered");

  // A body without the last mark keeps the block loading
  a_keep_loading: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !last_body) |=> in_ready)
    else $error("loading stopped without last body");

  // The final result ends the frame
  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && final_result) |=> (!out_valid && in_ready))
    else $error("frame did not end after final result");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(new_pos_y) && $stable(final_result)))
    else $error("stalled result changed");

endmodule

bind rigid_body_step_aabb_resolve rbs_checker u_rbs_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .last_body   (last_body),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .new_pos_y   (new_pos_y),
  .final_result(final_result)
);
